// ===== design/srtf_tick_scheduler_top_defines.svh =====
// Assertion macros for the shortest-remaining-time scheduler.
`ifndef SRTF_TICK_SCHEDULER_TOP_DEFINES_SVH
`define SRTF_TICK_SCHEDULER_TOP_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define SRTF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("srtf scheduler check failed");

// Consequence must hold in the cycle after the antecedent.
`define SRTF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("srtf scheduler check failed");

`endif

// ===== design/srtf_pkg.sv =====
// Types and codes shared by the scheduler modules.
`default_nettype none

package srtf_pkg;

   localparam logic CMD_ARRIVE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic [1:0] STATUS_RAN      = 2'd0;
   localparam logic [1:0] STATUS_IDLE     = 2'd1;
   localparam logic [1:0] STATUS_ACCEPTED = 2'd2;
   localparam logic [1:0] STATUS_REJECTED = 2'd3;

   typedef struct packed {
      logic        command;
      logic [7:0]  pid;
      logic [15:0] burst;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  run_pid;
      logic        new_slice;
      logic        finished;
      logic [31:0] now;
      logic [31:0] turnaround_time;
      logic [31:0] waiting_time;
      logic [31:0] response_time;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  pid;
      logic [15:0] remaining;
      logic [15:0] burst;
      logic [31:0] arrival;
      logic [31:0] first_run;
   } entry_row_type;

   typedef struct packed {
      logic load;
      logic rd_en;
      logic cmp_en;
      logic exec;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

// ===== design/srtf_ctrl.sv =====
// Sequencer: accept a word, sweep the process table, then commit the result.
`default_nettype none

module srtf_ctrl #(
   parameter int ENTRIES = 16,
   localparam int IdxW = $clog2(ENTRIES)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   out_free,
   output srtf_pkg::ctrl_cmd_type      cmd,
   output logic [IdxW-1:0]             rd_addr,
   output logic [IdxW-1:0]             cmp_idx
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_LAST = 2'd2;
   localparam logic [1:0] ST_EXEC = 2'd3;

   localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

   logic [1:0]      state_ff, state_in;
   logic [IdxW-1:0] cnt_ff, cnt_in;
   logic            cmp_en_ff;
   logic [IdxW-1:0] cmp_idx_ff;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd.load   = 1'b0;
      cmd.rd_en  = 1'b0;
      cmd.cmp_en = cmp_en_ff;
      cmd.exec   = 1'b0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            cnt_in    = cnt_ff + IdxW'(1);
            if (cnt_ff == LastIdx) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            // hold until the output register can take the word
            if (out_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_addr = cnt_ff;
   assign cmp_idx = cmp_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         cmp_en_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         cmp_en_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= cnt_ff;
   end

endmodule

`default_nettype wire

// ===== design/srtf_dp.sv =====
// Datapath: process table memory, minimum search, timing math and output register.
`default_nettype none

module srtf_dp #(
   parameter int ENTRIES = 16,
   localparam int IdxW = $clog2(ENTRIES)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire srtf_pkg::ctrl_cmd_type cmd,
   input  wire logic [IdxW-1:0]        rd_addr,
   input  wire logic [IdxW-1:0]        cmp_idx,
   input  wire srtf_pkg::req_type      req_data,
   input  wire logic                   rsp_ready,
   output logic                        out_free,
   output logic                        rsp_valid,
   output srtf_pkg::rsp_type           rsp_data
);

   srtf_pkg::entry_row_type mem [ENTRIES];
   srtf_pkg::entry_row_type rd_row_ff;
   srtf_pkg::entry_row_type best_row_ff;
   srtf_pkg::entry_row_type wr_row;
   srtf_pkg::req_type       req_ff;
   srtf_pkg::rsp_type       out_ff, out_in;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [ENTRIES-1:0] started_ff, started_in;
   logic               found_ff;
   logic [IdxW-1:0]    best_idx_ff;
   logic [31:0]        time_ff, time_in;
   logic [7:0]         run_pid_ff, run_pid_in;
   logic               run_valid_ff, run_valid_in;
   logic               out_full_ff;

   logic        is_tick;
   logic        cur_valid;
   logic        take;
   logic        arrive_ok;
   logic        wr_en;
   logic [15:0] new_rem;
   logic [31:0] first_run;
   logic [31:0] time_inc;
   logic [31:0] turnaround;

   assign is_tick   = (req_ff.command == srtf_pkg::CMD_TICK);
   assign cur_valid = valid_ff[cmp_idx];

   // ascending sweep with strict compares: ties in remaining time go to the lower pid, equal pids keep the lower slot
   always_comb begin
      if (is_tick) begin
         take = cur_valid &&
                (!found_ff ||
                 rd_row_ff.remaining < best_row_ff.remaining ||
                 (rd_row_ff.remaining == best_row_ff.remaining &&
                  rd_row_ff.pid < best_row_ff.pid));
      end else begin
         take = !cur_valid && !found_ff;
      end
   end

   assign arrive_ok  = found_ff && (req_ff.burst != 16'd0);
   assign new_rem    = best_row_ff.remaining - 16'd1;
   assign first_run  = started_ff[best_idx_ff] ? best_row_ff.first_run : time_ff;
   assign time_inc   = time_ff + 32'd1;
   assign turnaround = time_inc - best_row_ff.arrival;

   always_comb begin
      valid_in     = valid_ff;
      started_in   = started_ff;
      time_in      = time_ff;
      run_pid_in   = run_pid_ff;
      run_valid_in = run_valid_ff;
      wr_en        = 1'b0;
      wr_row       = best_row_ff;
      out_in       = '0;
      if (!is_tick) begin
         wr_row.pid       = req_ff.pid;
         wr_row.remaining = req_ff.burst;
         wr_row.burst     = req_ff.burst;
         wr_row.arrival   = time_ff;
         wr_row.first_run = '0;
         out_in.now       = time_ff;
         if (arrive_ok) begin
            wr_en                   = 1'b1;
            valid_in[best_idx_ff]   = 1'b1;
            started_in[best_idx_ff] = 1'b0;
            out_in.status           = srtf_pkg::STATUS_ACCEPTED;
         end else begin
            out_in.status = srtf_pkg::STATUS_REJECTED;
         end
      end else if (!found_ff) begin
         time_in       = time_inc;
         run_valid_in  = 1'b0;
         run_pid_in    = '0;
         out_in.status = srtf_pkg::STATUS_IDLE;
         out_in.now    = time_inc;
      end else begin
         wr_en                   = 1'b1;
         wr_row.remaining        = new_rem;
         wr_row.first_run        = first_run;
         started_in[best_idx_ff] = 1'b1;
         time_in                 = time_inc;
         out_in.status           = srtf_pkg::STATUS_RAN;
         out_in.run_pid          = best_row_ff.pid;
         out_in.new_slice        = !(run_valid_ff && run_pid_ff == best_row_ff.pid);
         out_in.now              = time_inc;
         if (new_rem == 16'd0) begin
            valid_in[best_idx_ff]   = 1'b0;
            started_in[best_idx_ff] = 1'b0;
            run_valid_in            = 1'b0;
            run_pid_in              = '0;
            out_in.finished         = 1'b1;
            out_in.turnaround_time  = turnaround;
            out_in.waiting_time     = turnaround - {16'd0, best_row_ff.burst};
            out_in.response_time    = first_run - best_row_ff.arrival;
         end else begin
            run_valid_in = 1'b1;
            run_pid_in   = best_row_ff.pid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[best_idx_ff] <= wr_row;
      end
      if (cmd.rd_en) begin
         rd_row_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.cmp_en && take) begin
         best_row_ff <= rd_row_ff;
         best_idx_ff <= cmp_idx;
      end
      if (cmd.exec) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         started_ff   <= '0;
         found_ff     <= 1'b0;
         time_ff      <= '0;
         run_pid_ff   <= '0;
         run_valid_ff <= 1'b0;
         out_full_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            found_ff <= 1'b0;
         end else if (cmd.cmp_en && take) begin
            found_ff <= 1'b1;
         end
         if (cmd.exec) begin
            valid_ff     <= valid_in;
            started_ff   <= started_in;
            time_ff      <= time_in;
            run_pid_ff   <= run_pid_in;
            run_valid_ff <= run_valid_in;
            out_full_ff  <= 1'b1;
         end else if (rsp_ready) begin
            out_full_ff <= 1'b0;
         end
      end
   end

   assign out_free  = !out_full_ff || rsp_ready;
   assign rsp_valid = out_full_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

// ===== design/srtf_tick_scheduler_top.sv =====
// Shortest-remaining-time-first scheduler: top level.
//
// req channel (req_valid/req_ready/req_data) takes one command word: an
// arrive (pid, burst) enters the process table, a tick runs the ready
// process with the least remaining time for one unit and advances time.
// rsp channel (rsp_valid/rsp_ready/rsp_data) returns exactly one word per
// command: status, run pid, slice start, finish flag, time, and on finish
// the turnaround, waiting and response times.
// After its command word is taken, a command sweeps the table memory one
// entry a cycle, drains the last compare, then commits its result word to
// the output register; no new command word is taken before that commit.
// A new command is taken as soon as the previous one has committed, even
// while its result word still waits in the output register.
// If the receiver stalls, the next command sweeps the table and then holds
// before commit until the output register frees.
// Reset empties the table, zeroes time and the running process, and
// drops any pending result word; no clearing pass is needed.
`default_nettype none
`include "srtf_tick_scheduler_top_defines.svh"

module srtf_tick_scheduler_top #(
   parameter int ENTRIES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire srtf_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output srtf_pkg::rsp_type      rsp_data
);

   localparam int IdxW = $clog2(ENTRIES);

   srtf_pkg::ctrl_cmd_type cmd;
   logic [IdxW-1:0]        rd_addr;
   logic [IdxW-1:0]        cmp_idx;
   logic                   out_free;

   srtf_ctrl #(
      .ENTRIES(ENTRIES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .out_free (out_free),
      .cmd      (cmd),
      .rd_addr  (rd_addr),
      .cmp_idx  (cmp_idx)
   );

   srtf_dp #(
      .ENTRIES(ENTRIES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_addr  (rd_addr),
      .cmp_idx  (cmp_idx),
      .req_data (req_data),
      .rsp_ready(rsp_ready),
      .out_free (out_free),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // one command in flight: busy right after a word is taken
   `SRTF_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   // no word is taken while the table sweep runs
   `SRTF_ASSERT_NOW(a_no_accept_in_scan, cmd.rd_en, !req_ready)
   // a commit always presents a result word
   `SRTF_ASSERT_NEXT(a_commit_presents, cmd.exec, rsp_valid)

endmodule

`default_nettype wire
